FILE: hw/rtl/tpti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpti_pkg
// shared widths and beat types for the triangle point test / interpolation
// ----------------------------------------------------------------------------
package tpti_pkg;

    localparam int COORD_BITS = 24;
    localparam int VALUE_BITS = 32;

    // derived widths
    localparam int DW = COORD_BITS + 1;     // coordinate difference
    localparam int PW = 2 * DW;             // edge product
    localparam int EW = PW + 1;             // edge value
    localparam int AW = EW + 2;             // doubled area
    localparam int LB = (EW + 1) / 2;       // low split of edge value
    localparam int HB = EW - LB;            // high split of edge value
    localparam int TW = EW + VALUE_BITS;    // weighted term
    localparam int NW = TW + 2;             // numerator
    localparam int QB = VALUE_BITS + 1;     // quotient bits kept
    localparam int RW = AW + QB;            // remainder

    localparam int IN_RAW  = 8 * COORD_BITS + 3 * VALUE_BITS;
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_RAW = VALUE_BITS + 3;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    typedef struct packed {
        logic [COORD_BITS-1:0]      px;
        logic [COORD_BITS-1:0]      py;
        logic [2:0][COORD_BITS-1:0] vx;   // a, b, c
        logic [2:0][COORD_BITS-1:0] vy;
        logic [2:0][VALUE_BITS-1:0] val;
    } query_t;

    typedef struct packed {
        logic [NW-1:0] nm;      // numerator magnitude
        logic [AW-1:0] dm;      // area magnitude
        logic          neg;
        logic          degen;
        logic          in_tri;
    } work_t;

    typedef struct packed {
        logic                  in_tri;
        logic                  degen;
        logic [VALUE_BITS-1:0] value;
        logic                  sat;
    } res_t;

endpackage

FILE: hw/rtl/triangle_point_test_interpolate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_point_test_interpolate
// barycentric point in triangle test and linear interpolation
// ----------------------------------------------------------------------------
// pipeline: 7 front stages, the queue, 34 divider stages and the output register
// throughput: one beat per cycle while the output is not stalled, set by the fully pipelined divider
// (one quotient bit per stage) and the front multiplier stages
// reset: rst_n asynchronous active low clears all valid bits and the queue
// ----------------------------------------------------------------------------
module triangle_point_test_interpolate (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // px, py, ax, ay, bx, by, cx, cy, value_a, value_b, value_c
    input  logic [tpti_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // inside_res, degenerate, interpolated, saturated, zero pad
    output logic [tpti_pkg::OUT_W-1:0] m_tdata
);
    import tpti_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int VB = VALUE_BITS;

    query_t query;
    work_t  f_data, q_data;
    res_t   res;
    logic   f_valid, q_full, q_empty, q_pop, push;

    // unpack the input beat, vertices indexed a, b, c
    assign query.px     = s_tdata[0*CB +: CB];
    assign query.py     = s_tdata[1*CB +: CB];
    assign query.vx[0]  = s_tdata[2*CB +: CB];
    assign query.vy[0]  = s_tdata[3*CB +: CB];
    assign query.vx[1]  = s_tdata[4*CB +: CB];
    assign query.vy[1]  = s_tdata[5*CB +: CB];
    assign query.vx[2]  = s_tdata[6*CB +: CB];
    assign query.vy[2]  = s_tdata[7*CB +: CB];
    assign query.val[0] = s_tdata[8*CB +: VB];
    assign query.val[1] = s_tdata[8*CB + VB +: VB];
    assign query.val[2] = s_tdata[8*CB + 2*VB +: VB];

    // front: edges, inside test, numerator
    tpti_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (query),
        .out_valid (f_valid),
        .out_full  (q_full),
        .out_data  (f_data)
    );

    assign push = f_valid && !q_full;

    // decoupling queue
    tpti_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (f_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    // back: division and saturation
    tpti_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    // pack the result beat
    assign m_tdata = {(OUT_W - OUT_RAW)'(0), res.sat, res.value, res.degen, res.in_tri};

endmodule

FILE: hw/rtl/tpti_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpti_front
// edge functions, inside test, area and weighted numerator, 7 stages
// ----------------------------------------------------------------------------
module tpti_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tpti_pkg::query_t in_data,
    output logic            out_valid,
    input  logic            out_full,
    output tpti_pkg::work_t out_data
);
    import tpti_pkg::*;

    logic [6:0] v_reg;
    logic        en;

    logic signed [DW-1:0] d1_reg [3];
    logic signed [DW-1:0] d2_reg [3];
    logic signed [DW-1:0] d3_reg [3];
    logic signed [DW-1:0] d4_reg [3];
    logic [2:0][VALUE_BITS-1:0] w1_reg, w2_reg, w3_reg;
    logic signed [PW-1:0] p1_reg [3];
    logic signed [PW-1:0] p2_reg [3];
    logic signed [EW-1:0] e3_reg [3];
    logic signed [HB+VALUE_BITS-1:0]   ph4_reg [3];
    logic signed [LB+1+VALUE_BITS-1:0] pl4_reg [3];
    logic signed [AW-1:0] area4_reg, area5_reg, area6_reg;
    logic                 in4_reg, in5_reg, in6_reg;
    logic signed [TW-1:0] t5_reg [3];
    logic signed [NW-1:0] num6_reg;
    work_t                out_reg;

    assign en        = !v_reg[6] || !out_full;
    assign in_ready  = en;
    assign out_valid = v_reg[6];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        int j;
        int k;
        logic n0, n1, n2, z0, z1, z2;
        if (en)
        begin
            // stage 1: differences, edge i runs from vertex i to vertex j
            for (int i = 0; i < 3; i++)
            begin
                j = (i == 2) ? 0 : i + 1;
                k = (i == 0) ? 2 : i - 1;
                d1_reg[i] <= DW'($signed(in_data.vy[i])) - DW'($signed(in_data.vy[j]));
                d2_reg[i] <= DW'($signed(in_data.px)) - DW'($signed(in_data.vx[i]));
                d3_reg[i] <= DW'($signed(in_data.vx[j])) - DW'($signed(in_data.vx[i]));
                d4_reg[i] <= DW'($signed(in_data.py)) - DW'($signed(in_data.vy[i]));
                // edge opposite a vertex weights that vertex's value
                w1_reg[i] <= in_data.val[k];
            end
            // stage 2: products
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i] <= d1_reg[i] * d2_reg[i];
                p2_reg[i] <= d3_reg[i] * d4_reg[i];
            end
            w2_reg <= w1_reg;
            // stage 3: edge values
            for (int i = 0; i < 3; i++)
            begin
                e3_reg[i] <= EW'(p1_reg[i]) + EW'(p2_reg[i]);
            end
            w3_reg <= w2_reg;
            // stage 4: area, inside, split partial products
            area4_reg <= AW'(e3_reg[0]) + AW'(e3_reg[1]) + AW'(e3_reg[2]);
            n0 = e3_reg[0][EW-1];
            n1 = e3_reg[1][EW-1];
            n2 = e3_reg[2][EW-1];
            z0 = (e3_reg[0] == '0);
            z1 = (e3_reg[1] == '0);
            z2 = (e3_reg[2] == '0);
            in4_reg <= (!n0 && !n1 && !n2) || ((n0 || z0) && (n1 || z1) && (n2 || z2));
            for (int i = 0; i < 3; i++)
            begin
                ph4_reg[i] <= $signed(e3_reg[i][EW-1:LB]) * $signed(w3_reg[i]);
                pl4_reg[i] <= $signed({1'b0, e3_reg[i][LB-1:0]}) * $signed(w3_reg[i]);
            end
            // stage 5: recombine partial products
            for (int i = 0; i < 3; i++)
            begin
                t5_reg[i] <= (TW'(ph4_reg[i]) <<< LB) + TW'(pl4_reg[i]);
            end
            area5_reg <= area4_reg;
            in5_reg   <= in4_reg;
            // stage 6: numerator sum
            num6_reg  <= NW'(t5_reg[0]) + NW'(t5_reg[1]) + NW'(t5_reg[2]);
            area6_reg <= area5_reg;
            in6_reg   <= in5_reg;
            // stage 7: magnitudes and sign
            out_reg.nm     <= num6_reg[NW-1] ? NW'(-num6_reg) : NW'(num6_reg);
            out_reg.dm     <= area6_reg[AW-1] ? AW'(-area6_reg) : AW'(area6_reg);
            out_reg.neg    <= num6_reg[NW-1] ^ area6_reg[AW-1];
            out_reg.degen  <= (area6_reg == '0);
            out_reg.in_tri <= in6_reg;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("front pipe moved while stalled");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[6] && out_full) |-> !in_ready)
        else $error("front accepted while blocked");
    a_deg: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[6] && out_data.degen) |-> (out_data.dm == '0))
        else $error("degenerate with nonzero area");

endmodule

FILE: hw/rtl/tpti_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpti_queue
// four-entry queue between front and back
// ----------------------------------------------------------------------------
module tpti_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tpti_pkg::work_t push_data,
    output logic            full,
    input  logic            pop,
    output tpti_pkg::work_t pop_data,
    output logic            empty
);
    import tpti_pkg::*;

    work_t      mem [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;

    assign full     = (cnt_reg == 3'd4);
    assign empty    = (cnt_reg == 3'd0);
    assign pop_data = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end

    a_ovf: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue overflow");
    a_unf: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue underflow");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4)
        else $error("queue count out of range");

endmodule

FILE: hw/rtl/tpti_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpti_back
// pipelined restoring divider, rounding, saturation and output register
// ----------------------------------------------------------------------------
module tpti_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    output logic            q_pop,
    input  tpti_pkg::work_t q_data,
    output logic            out_valid,
    input  logic            out_ready,
    output tpti_pkg::res_t  out_data
);
    import tpti_pkg::*;

    typedef struct packed {
        logic [RW-1:0]         rem;
        logic [QB-1:0]         q;
        logic [AW-1:0]         dm;
        logic                  neg;
        logic                  degen;
        logic                  in_tri;
        logic                  ovf;
    } stage_t;

    localparam logic [QB:0] POS_MAX = ((QB+1)'(1) << (VALUE_BITS - 1)) - (QB+1)'(1);

    logic [QB:0] v_reg;
    stage_t      st_reg [QB+1];
    logic        out_valid_reg;
    res_t        res_reg;
    logic        en;

    assign en        = !out_valid_reg || out_ready;
    assign q_pop     = en && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[QB-1:0], q_pop};
            out_valid_reg <= v_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [RW-1:0] sh;
        logic [RW:0]   twice;
        logic [QB:0]   qr;
        logic          up;
        stage_t        s;
        if (en)
        begin
            // quotient beyond kept bits means certain saturation unless the area is zero
            st_reg[0].rem    <= RW'(q_data.nm);
            st_reg[0].q      <= '0;
            st_reg[0].dm     <= q_data.dm;
            st_reg[0].neg    <= q_data.neg;
            st_reg[0].degen  <= q_data.degen;
            st_reg[0].in_tri <= q_data.in_tri;
            st_reg[0].ovf    <= RW'(q_data.nm) >= (RW'(q_data.dm) << QB);
            // one quotient bit per stage, msb first
            for (int j = 1; j <= QB; j++)
            begin
                s  = st_reg[j-1];
                sh = RW'(s.dm) << (QB - j);
                if (s.rem >= sh)
                begin
                    s.rem        = s.rem - sh;
                    s.q[QB - j]  = 1'b1;
                end
                st_reg[j] <= s;
            end
            // round the magnitude half up, then clip
            s     = st_reg[QB];
            twice = {s.rem, 1'b0};
            up    = twice >= (RW+1)'(s.dm);
            qr    = (QB+1)'(s.q) + (QB+1)'(up);
            res_reg.in_tri <= s.in_tri;
            res_reg.degen  <= s.degen;
            if (s.degen || (!s.ovf && qr == '0))
            begin
                res_reg.value <= '0;
                res_reg.sat   <= 1'b0;
            end
            else if (!s.neg)
            begin
                if (s.ovf || qr > POS_MAX)
                begin
                    res_reg.value <= POS_MAX[VALUE_BITS-1:0];
                    res_reg.sat   <= 1'b1;
                end
                else
                begin
                    res_reg.value <= qr[VALUE_BITS-1:0];
                    res_reg.sat   <= 1'b0;
                end
            end
            else
            begin
                if (s.ovf || qr > POS_MAX + (QB+1)'(1))
                begin
                    res_reg.value <= {1'b1, {(VALUE_BITS-1){1'b0}}};
                    res_reg.sat   <= 1'b1;
                end
                else
                begin
                    res_reg.value <= VALUE_BITS'((QB+1)'(0) - qr);
                    res_reg.sat   <= 1'b0;
                end
            end
        end
    end

    a_deg: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.degen) |-> (!res_reg.sat && res_reg.value == '0))
        else $error("degenerate result not zero");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |-> !q_pop)
        else $error("pop while back end stalled");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (en && !q_empty) |=> v_reg[0])
        else $error("popped beat lost");

endmodule
